// ===== src/shbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sample-and-hold bit crusher package
// Shared payload types, register indexes and fixed-point constants for the
// crusher datapath.
// ----------------------------------------------------------------------------
package shbc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int AMOUNT_W = 17;
    localparam int AMT_FRAC = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CRUSH_ENABLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

    localparam logic [AMOUNT_W-1:0] AMT_ONE = 17'd65536;
    // Smallest amount for which amount * 1000 reaches full scale.
    localparam logic [AMOUNT_W-1:0] AMT_MIN = 17'd66;
    // Sixteen bits of depth in Q.16, the starting point of the bit count.
    localparam logic [20:0] BITS_START = 21'h100000;
    localparam logic [15:0] EXP_C1 = 16'd43049;
    localparam logic [14:0] EXP_C2 = 15'd22487;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7fffff;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;

    // Quotient bits produced by the divider, one per cycle.
    localparam int DIV_STEPS = 24;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic [AMOUNT_W-1:0]        crush_amount;
    } shbc_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } shbc_out_t;

endpackage

// ===== src/sample_hold_bit_crusher.sv =====
// Flow: a frame that passes through (crusher off or negligible amount) goes
// straight to the output register; a crushed frame is processed channel by
// channel. The input stalls until the result is loaded for output, so frames
// do not overlap; the restoring divider produces one quotient bit a cycle
// (24 steps per channel).
// Reset: asynchronous, active low; hold registers and counter clear, the
// crusher is off and both channels are active.
// ----------------------------------------------------------------------------
// Sample-and-hold bit crusher
// Lowers sample rate and bit depth of a stereo frame under a sequencer that
// drives one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
module sample_hold_bit_crusher (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  shbc_pkg::shbc_in_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output shbc_pkg::shbc_out_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [shbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [shbc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXP0  = 4'd1;
    localparam logic [3:0] S_EXP1  = 4'd2;
    localparam logic [3:0] S_EXP2  = 4'd3;
    localparam logic [3:0] S_MAG   = 4'd4;
    localparam logic [3:0] S_ROUND = 4'd5;
    localparam logic [3:0] S_DIVI  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_MULD  = 4'd8;
    localparam logic [3:0] S_BLEND = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;

    logic        crush_enable_reg;
    logic [1:0]  channel_count_reg;
    logic [23:0] held_left_reg;
    logic [23:0] held_right_reg;
    logic [3:0]  hold_count_reg;

    logic [23:0] l_reg;
    logic [23:0] r_reg;
    logic [16:0] a_reg;
    logic [4:0]  n_reg;
    logic [15:0] x_reg;
    logic [16:0] e_reg;
    logic [41:0] prod_reg;
    logic [18:0] k_reg;
    logic [17:0] rem_reg;
    logic [23:0] dq_reg;
    logic [4:0]  div_cnt_reg;
    logic        ch_reg;
    logic        d_neg_reg;
    logic [23:0] res_l_reg;
    logic [23:0] res_r_reg;
    logic        out_valid_reg;
    shbc_pkg::shbc_out_t out_data_reg;

    // Accept-time decode
    logic        accept;
    logic        two_ch;
    logic [16:0] a_sat;
    logic        crush_on;
    logic [20:0] amt15;
    logic [4:0]  hold_len;
    logic [4:0]  cnt_next;
    logic        capture;
    logic [20:0] amt12;
    logic [20:0] bits_q16;

    // Datapath
    logic [23:0] held_cur;
    logic        h_neg;
    logic [23:0] h_mag;
    logic [23:0] in_cur;
    logic [57:0] p_sh;
    logic [57:0] p_rnd;
    logic [5:0]  num_shift;
    logic [57:0] num_sh;
    logic [57:0] div_in;
    logic [17:0] trial;
    logic        trial_ge;
    logic [25:0] q_s;
    logic [25:0] d_s;
    logic [24:0] d_mag;
    logic [25:0] r_mag;
    logic [26:0] sum_s;
    logic [23:0] blend_res;
    logic        out_load;

    logic [24:0] mul_a;
    logic [16:0] mul_b;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign two_ch    = channel_count_reg[1];

    always_comb
    begin
        a_sat    = (in_data.crush_amount > shbc_pkg::AMT_ONE) ? shbc_pkg::AMT_ONE
                                                                : in_data.crush_amount;
        crush_on = crush_enable_reg && (a_sat >= shbc_pkg::AMT_MIN);
        amt15    = {a_sat, 4'b0000} - {4'b0000, a_sat};
        hold_len = {1'b0, amt15[19:16]} + 5'd1;
        cnt_next = {1'b0, hold_count_reg} + 5'd1;
        capture  = (cnt_next >= hold_len);
        amt12    = {1'b0, a_sat, 3'b000} + {2'b00, a_sat, 2'b00};
        bits_q16 = shbc_pkg::BITS_START - amt12;
    end

    always_comb
    begin
        held_cur  = ch_reg ? held_right_reg : held_left_reg;
        h_neg     = held_cur[23];
        h_mag     = h_neg ? (24'd0 - held_cur) : held_cur;
        in_cur    = ch_reg ? r_reg : l_reg;

        // Scale by 2^n, then round to whole quantizer steps.
        p_sh      = {17'd0, prod_reg[40:0]} << n_reg;
        p_rnd     = p_sh + (58'd1 << 38);

        num_shift = 6'd39 - {1'b0, n_reg};
        num_sh    = {39'd0, k_reg} << num_shift;
        div_in    = num_sh + {42'd0, e_reg[16:1]};

        trial     = {rem_reg[16:0], dq_reg[23]};
        trial_ge  = (trial >= {1'b0, e_reg});

        q_s       = h_neg ? (26'd0 - {2'b00, dq_reg}) : {2'b00, dq_reg};
        d_s       = q_s - {{2{in_cur[23]}}, in_cur};
        d_mag     = d_s[25] ? 25'(26'd0 - d_s) : d_s[24:0];

        r_mag     = 26'((prod_reg + 42'd32768) >> 16);
        sum_s     = {{3{in_cur[23]}}, in_cur}
                  + (d_neg_reg ? (27'd0 - {1'b0, r_mag}) : {1'b0, r_mag});
        if (sum_s[26:23] == 4'b0000 || sum_s[26:23] == 4'b1111)
        begin
            blend_res = sum_s[23:0];
        end
        else
        begin
            blend_res = sum_s[26] ? shbc_pkg::SMP_MIN : shbc_pkg::SMP_MAX;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = 25'd0;
        mul_b = 17'd0;
        unique case (state_reg)
            S_EXP0:
            begin
                mul_a = {10'd0, shbc_pkg::EXP_C2};
                mul_b = {1'b0, x_reg};
            end
            S_EXP1:
            begin
                mul_a = {9'd0, x_reg};
                mul_b = {1'b0, shbc_pkg::EXP_C1} + {1'b0, prod_reg[31:16]};
            end
            S_MAG:
            begin
                mul_a = {1'b0, h_mag};
                mul_b = e_reg;
            end
            S_MULD:
            begin
                mul_a = d_mag;
                mul_b = a_reg;
            end
            default:
            begin
                mul_a = 25'd0;
                mul_b = 17'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {17'd0, mul_a} * {25'd0, mul_b};
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = crush_on ? S_EXP0 : S_DONE;
                end
            end
            S_EXP0:  state_next = S_EXP1;
            S_EXP1:  state_next = S_EXP2;
            S_EXP2:  state_next = S_MAG;
            S_MAG:   state_next = S_ROUND;
            S_ROUND: state_next = S_DIVI;
            S_DIVI:  state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == 5'(shbc_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_MULD;
                end
            end
            S_MULD:  state_next = S_BLEND;
            S_BLEND: state_next = (!ch_reg && two_ch) ? S_MAG : S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and hold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            crush_enable_reg  <= 1'b0;
            channel_count_reg <= 2'd2;
            held_left_reg     <= 24'd0;
            held_right_reg    <= 24'd0;
            hold_count_reg    <= 4'd0;
            out_valid_reg     <= 1'b0;
            ch_reg            <= 1'b0;
            div_cnt_reg       <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    shbc_pkg::REG_CRUSH_ENABLE:  crush_enable_reg  <= cfg_data[0];
                    shbc_pkg::REG_CHANNEL_COUNT: channel_count_reg <= cfg_data;
                    default:                     crush_enable_reg  <= crush_enable_reg;
                endcase
            end

            // The hold counter and capture are settled as the frame is taken.
            if (accept && crush_on)
            begin
                if (capture)
                begin
                    hold_count_reg <= 4'd0;
                    held_left_reg  <= in_data.left_in;
                    if (two_ch)
                    begin
                        held_right_reg <= in_data.right_in;
                    end
                end
                else
                begin
                    hold_count_reg <= cnt_next[3:0];
                end
            end

            if (accept)
            begin
                ch_reg <= 1'b0;
            end
            else if (state_reg == S_BLEND)
            begin
                ch_reg <= 1'b1;
            end

            if (state_reg == S_DIVI)
            begin
                div_cnt_reg <= 5'd0;
            end
            else if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            l_reg     <= in_data.left_in;
            r_reg     <= in_data.right_in;
            a_reg     <= a_sat;
            n_reg     <= bits_q16[20:16];
            x_reg     <= bits_q16[15:0];
            res_l_reg <= in_data.left_in;
            res_r_reg <= in_data.right_in;
        end

        case (state_reg)
            S_EXP2:  e_reg <= 17'd65536 + {1'b0, prod_reg[31:16]};
            S_ROUND: k_reg <= p_rnd[57:39];
            S_DIVI:
            begin
                rem_reg <= {1'b0, div_in[40:24]};
                dq_reg  <= div_in[23:0];
            end
            S_DIV:
            begin
                rem_reg <= trial_ge ? (trial - {1'b0, e_reg}) : trial;
                dq_reg  <= {dq_reg[22:0], trial_ge};
            end
            S_MULD:  d_neg_reg <= d_s[25];
            S_BLEND:
            begin
                if (ch_reg)
                begin
                    res_r_reg <= blend_res;
                end
                else
                begin
                    res_l_reg <= blend_res;
                end
            end
            default: d_neg_reg <= d_neg_reg;
        endcase

        if (out_load)
        begin
            out_data_reg.left_out  <= res_l_reg;
            out_data_reg.right_out <= res_r_reg;
        end
    end

    // A transferred frame keeps the sequencer busy in the cycle after the transfer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input taken again straight after a transfer");

    // A frame that is not crushed leaves the hold state untouched.
    a_bypass_keeps_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !crush_on) |=>
            ($stable(hold_count_reg) && $stable(held_left_reg) && $stable(held_right_reg)))
        else $error("hold state changed on a bypassed frame");

    // The partial remainder always stays below the divisor.
    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < {1'b0, e_reg}))
        else $error("divider remainder out of range");

    // The right channel is only processed when both channels are active.
    a_right_only_stereo: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAG && ch_reg) |-> two_ch)
        else $error("right channel crushed in mono mode");

    // The result register is never overwritten while a result is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> !out_stall)
        else $error("pending result overwritten");

endmodule
